@@ rtl/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while reset is asserted
`define DFR_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define DFR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/dfr_pkg.sv @@
`timescale 1ns / 1ps

package dfr_pkg;

	// sync pair that opens a frame
	localparam logic [7:0] SYNC_FIRST  = 8'hC2;
	localparam logic [7:0] SYNC_SECOND = 8'h3D;

	// default buffer size, sets the reset value of the length limit
	localparam int DFR_BUFFER_BYTES = 32'h400;

	// verdict codes carried on end beats
	localparam logic [1:0] ST_GOOD         = 2'd0;
	localparam logic [1:0] ST_CHECKSUM_ERR = 2'd1;
	localparam logic [1:0] ST_LENGTH_ERR   = 2'd2;

	// header byte positions
	localparam logic [1:0] HDR_LEN_LO = 2'd2;
	localparam logic [1:0] HDR_LEN_HI = 2'd3;

	// one result beat
	typedef struct packed {
		logic [7:0]  payload_byte;
		logic        end_of_frame;
		logic [1:0]  frame_status;
		logic [15:0] payload_count;
	} dfr_result_t;

	// result handed from the core to the output register
	typedef struct packed {
		logic        valid;
		dfr_result_t res;
	} dfr_beat_t;

endpackage

@@ rtl/dfr_if.sv @@
`timescale 1ns / 1ps

// received byte channel
interface dfr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
	modport monitor (input valid, input rx_byte, input ready);
endinterface

// deframed result channel
interface dfr_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  payload_byte;
	logic        end_of_frame;
	logic [1:0]  frame_status;
	logic [15:0] payload_count;

	modport source (output valid, output payload_byte, output end_of_frame,
		output frame_status, output payload_count, input ready);
	modport sink (input valid, input payload_byte, input end_of_frame,
		input frame_status, input payload_count, output ready);
	modport monitor (input valid, input payload_byte, input end_of_frame,
		input frame_status, input payload_count, input ready);
endinterface

@@ rtl/serial_frame_deframer.sv @@
`timescale 1ns / 1ps

// serial frame deframer
// rx carries one received serial byte per beat; the block hunts for the sync
// pair C2 3D, then reads signal, sequence and a 16-bit length (low byte first).
// tx carries one beat per payload byte as it arrives, and one end beat per
// frame with the verdict (good, checksum error, length error) and the count
// of payload bytes sent. sync and header bytes produce no beat, except a bad
// length, which ends the frame at once; the checksum byte gives the end beat.
// bad frames are not withheld: the receiver drops their payload on the verdict.
// cfg_we/cfg_data write the largest accepted length; write only while idle.
// throughput: one rx beat per cycle while tx is not stalled, set by the single output register.
// a result is registered and is valid on tx in the cycle after its rx beat is accepted.
// when tx stalls, the held result waits and rx.ready stays low until tx is
// taken; rx.ready is high whenever the output register is empty or draining.
// reset (arst_n low) drops any held result, returns to sync hunt and loads
// the length limit with BUFFER_BYTES - 3.
module serial_frame_deframer #(
	parameter int BUFFER_BYTES = dfr_pkg::DFR_BUFFER_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	dfr_in_if.sink      rx,
	dfr_out_if.source   tx
);

	dfr_pkg::dfr_beat_t beat;
	logic               free;
	logic               accept;

	// input taken whenever the output register can load
	assign rx.ready = free;
	assign accept   = rx.valid && free;

	dfr_core #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data),
		.accept  (accept),
		.rx_byte (rx.rx_byte),
		.beat    (beat)
	);

	dfr_out_reg u_out (
		.clk   (clk),
		.arst_n(arst_n),
		.beat  (beat),
		.free  (free),
		.tx    (tx)
	);

endmodule

@@ rtl/dfr_core.sv @@
`timescale 1ns / 1ps

module dfr_core #(
	parameter int BUFFER_BYTES = dfr_pkg::DFR_BUFFER_BYTES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [15:0]       cfg_data,
	input  logic              accept,
	input  logic [7:0]        rx_byte,
	output dfr_pkg::dfr_beat_t beat
);

	localparam logic [15:0] MaxLenReset = 16'(BUFFER_BYTES - 3);

	logic [15:0] max_len_q;
	logic [7:0]  prev_q, prev_d;
	logic        in_frame_q, in_frame_d;
	logic [15:0] pos_q, pos_d;
	logic [7:0]  xor_q, xor_d;
	logic [7:0]  len_lo_q, len_lo_d;
	logic [15:0] len_q, len_d;

	logic [1:0]  hdr_pos;
	logic [15:0] len_field;
	logic        len_bad;
	logic        last_byte;

	assign hdr_pos   = pos_q[1:0];
	assign len_field = {rx_byte, len_lo_q};
	assign len_bad   = (len_field == 16'd0) || (len_field > max_len_q);
	assign last_byte = ({1'b0, pos_q} + 17'd1) >= {1'b0, len_q};

	// length limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MaxLenReset;
		end else if (cfg_we) begin
			max_len_q <= cfg_data;
		end
	end

	// next state and result for the current byte
	always_comb begin
		prev_d      = prev_q;
		in_frame_d  = in_frame_q;
		pos_d       = pos_q;
		xor_d       = xor_q;
		len_lo_d    = len_lo_q;
		len_d       = len_q;
		beat        = '0;
		if (!in_frame_q) begin
			if (prev_q == dfr_pkg::SYNC_FIRST && rx_byte == dfr_pkg::SYNC_SECOND) begin
				in_frame_d  = 1'b1;
				pos_d       = 16'd0;
				len_d       = 16'd0;
				xor_d       = dfr_pkg::SYNC_FIRST ^ dfr_pkg::SYNC_SECOND;
			end
			prev_d = rx_byte;
		end else if (len_q == 16'd0) begin
			if (hdr_pos == dfr_pkg::HDR_LEN_HI) begin
				if (len_bad) begin
					in_frame_d              = 1'b0;
					pos_d                   = 16'd0;
					beat.valid              = 1'b1;
					beat.res.end_of_frame   = 1'b1;
					beat.res.frame_status   = dfr_pkg::ST_LENGTH_ERR;
				end else begin
					xor_d       = xor_q ^ rx_byte;
					len_d       = len_field;
					pos_d       = 16'd0;
				end
			end else begin
				if (hdr_pos == dfr_pkg::HDR_LEN_LO) begin
					len_lo_d = rx_byte;
				end
				xor_d = xor_q ^ rx_byte;
				pos_d = {14'd0, hdr_pos} + 16'd1;
			end
		end else if (last_byte) begin
			in_frame_d             = 1'b0;
			pos_d                  = 16'd0;
			len_d                  = 16'd0;
			beat.valid             = 1'b1;
			beat.res.end_of_frame  = 1'b1;
			beat.res.frame_status  = (rx_byte == xor_q) ? dfr_pkg::ST_GOOD
				: dfr_pkg::ST_CHECKSUM_ERR;
			beat.res.payload_count = pos_q;
		end else begin
			xor_d                 = xor_q ^ rx_byte;
			pos_d                 = pos_q + 16'd1;
			beat.valid            = 1'b1;
			beat.res.payload_byte = rx_byte;
		end
		if (!accept) begin
			beat.valid = 1'b0;
		end
	end

	// frame state, advanced on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= 8'd0;
			in_frame_q  <= 1'b0;
			pos_q       <= 16'd0;
			xor_q       <= 8'd0;
			len_lo_q    <= 8'd0;
			len_q       <= 16'd0;
		end else if (accept) begin
			prev_q      <= prev_d;
			in_frame_q  <= in_frame_d;
			pos_q       <= pos_d;
			xor_q       <= xor_d;
			len_lo_q    <= len_lo_d;
			len_q       <= len_d;
		end
	end

endmodule

@@ rtl/dfr_out_reg.sv @@
`timescale 1ns / 1ps

module dfr_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  dfr_pkg::dfr_beat_t beat,
	output logic               free,
	dfr_out_if.source          tx
);

	logic                 valid_q;
	dfr_pkg::dfr_result_t res_q;

	// register can load when empty or being drained
	assign free = !valid_q || tx.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= beat.valid;
		end
	end

	// result data, no reset needed
	always_ff @(posedge clk) begin
		if (free && beat.valid) begin
			res_q <= beat.res;
		end
	end

	assign tx.valid         = valid_q;
	assign tx.payload_byte  = res_q.payload_byte;
	assign tx.end_of_frame  = res_q.end_of_frame;
	assign tx.frame_status  = res_q.frame_status;
	assign tx.payload_count = res_q.payload_count;

endmodule

@@ rtl/dfr_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dfr_checker (
	input logic        clk,
	input logic        arst_n,
	dfr_in_if.sink     rx,
	dfr_out_if.source  tx
);

	// stalled result beat holds
	`DFR_ASSERT(a_tx_hold, clk, arst_n, (tx.valid && !tx.ready) |=> (tx.valid && $stable(tx.payload_byte) && $stable(tx.end_of_frame) && $stable(tx.frame_status) && $stable(tx.payload_count)), "tx beat changed while stalled")

	// payload beats carry no verdict and no count
	`DFR_ASSERT(a_payload_clean, clk, arst_n, (tx.valid && !tx.end_of_frame) |-> (tx.frame_status == dfr_pkg::ST_GOOD && tx.payload_count == 16'd0), "payload beat with verdict fields set")

	// end beats carry a zero byte and a known verdict
	`DFR_ASSERT(a_end_clean, clk, arst_n, (tx.valid && tx.end_of_frame) |-> (tx.payload_byte == 8'd0 && (tx.frame_status == dfr_pkg::ST_GOOD || tx.frame_status == dfr_pkg::ST_CHECKSUM_ERR || tx.frame_status == dfr_pkg::ST_LENGTH_ERR)), "malformed end beat")

	// input is taken whenever the output side is not stalled
	`DFR_ASSERT_ALWAYS(a_rx_ready, clk, rx.ready == (!tx.valid || tx.ready), "rx ready does not follow output register")

	// no result during reset
	`DFR_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |-> !tx.valid, "tx valid during reset")

endmodule

bind serial_frame_deframer dfr_checker u_dfr_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.rx    (rx),
	.tx    (tx)
);
